>>> src/lr_pkg.sv
package lr_pkg;

	// Coordinate and arithmetic widths
	localparam int COORD_BITS = 10;
	localparam int DELTA_BITS = COORD_BITS + 1;
	localparam int ERR_BITS   = COORD_BITS + 2;

	localparam logic [COORD_BITS-1:0] GRID_RESET = COORD_BITS'(400);

	typedef enum logic {
		CMD_START = 1'b0,
		CMD_STEP  = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		PH_WALK   = 2'd0,
		PH_FIRST  = 2'd1,
		PH_SECOND = 2'd2
	} phase_t;

	typedef struct packed {
		logic straight;
		logic minor_down;
		logic major_y;
	} line_mode_t;

	typedef struct packed {
		cmd_t                  command;
		logic [COORD_BITS-1:0] x_start;
		logic [COORD_BITS-1:0] y_start;
		logic [COORD_BITS-1:0] x_end;
		logic [COORD_BITS-1:0] y_end;
	} item_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] pixel_x;
		logic [COORD_BITS-1:0] pixel_y;
		logic                  visible;
		logic                  last;
	} result_t;

	// Everything the stepper needs to begin a line
	typedef struct packed {
		line_mode_t                  mode;
		logic [COORD_BITS-1:0]       major_pos;
		logic [COORD_BITS-1:0]       minor_pos;
		logic [COORD_BITS-1:0]       major_limit;
		logic signed [ERR_BITS-1:0]  error_term;
		logic [DELTA_BITS-1:0]       delta_major;
		logic [DELTA_BITS-1:0]       delta_minor;
		logic [COORD_BITS-1:0]       x_start;
		logic [COORD_BITS-1:0]       y_start;
		logic [COORD_BITS-1:0]       x_end;
		logic [COORD_BITS-1:0]       y_end;
	} line_setup_t;

	typedef struct packed {
		cmd_t        command;
		line_setup_t setup;
	} cmd_entry_t;

	typedef struct packed {
		logic   active;
		phase_t phase;
	} back_status_t;

endpackage

>>> src/line_rasterizer.sv
// Line rasterizer: push a start word (command 0) with two endpoints, then one step word
// (command 1) per pixel; each step returns one result word with the pixel, a visibility
// flag against grid_size and a last flag on the line's final pixel. Start words and steps
// with no line in progress return nothing. Both sides sustain one word per cycle: the
// classifier is combinational and the stepper takes a word whenever one is queued and the
// result queue has room, so the rate is set only by the two queues staying unblocked. With
// no stalls a result word reaches the result ports once its step word is registered in the
// command queue and handled by the stepper and its pixel is registered in the result queue.
// grid_size may be written only while no words are in flight.
module line_rasterizer import lr_pkg::*; #(
	parameter int CMD_DEPTH    = 2,
	parameter int RESULT_DEPTH = 2
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  item_t                 item,
	output logic                  full,
	output logic                  empty,
	input  logic                  pop,
	output result_t               result,
	input  logic                  grid_we,
	input  logic [COORD_BITS-1:0] grid_data
);

	logic [COORD_BITS-1:0] grid_q;
	cmd_entry_t            entry;
	cmd_entry_t            cmd_head;
	logic                  cmd_empty;
	logic                  cmd_pop;
	logic                  res_full;
	logic                  res_push;
	result_t               res_word;
	back_status_t          back_status;

	// Hold the grid size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_q <= GRID_RESET;
		end else if (grid_we) begin
			grid_q <= grid_data;
		end
	end

	// Classify the incoming word
	lr_front u_front (
		.item  (item),
		.entry (entry)
	);

	// Queue classified words for the stepper
	lr_fifo #(
		.WIDTH ($bits(cmd_entry_t)),
		.DEPTH (CMD_DEPTH)
	) u_cmd_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push),
		.wr_data (entry),
		.full    (full),
		.rd_en   (cmd_pop),
		.rd_data (cmd_head),
		.empty   (cmd_empty)
	);

	// Step the active line
	lr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.grid_size (grid_q),
		.cmd_valid (!cmd_empty),
		.cmd_word  (cmd_head),
		.cmd_pop   (cmd_pop),
		.res_room  (!res_full),
		.res_push  (res_push),
		.res_word  (res_word),
		.status    (back_status)
	);

	// Queue result words for the consumer
	lr_fifo #(
		.WIDTH ($bits(result_t)),
		.DEPTH (RESULT_DEPTH)
	) u_res_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_push),
		.wr_data (res_word),
		.full    (res_full),
		.rd_en   (pop),
		.rd_data (result),
		.empty   (empty)
	);

`ifndef SYNTHESIS
	// A result word only comes from a step word popped off the command queue
	a_push_from_step: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> (cmd_pop && cmd_head.command == CMD_STEP))
		else $error("result pushed without a step word");

	// The last pixel of a line ends the line
	a_last_ends_line: assert property (@(posedge clk) disable iff (!arst_n)
		(res_push && res_word.last) |=> !back_status.active)
		else $error("line still active after last pixel");

	// Endpoint phases only occur while a line is active
	a_phase_active: assert property (@(posedge clk) disable iff (!arst_n)
		(back_status.phase != PH_WALK) |-> back_status.active)
		else $error("endpoint phase without active line");

	// The result queue fills only from the stepper
	a_empty_fall: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(empty) |-> $past(res_push))
		else $error("result queue filled without a push");
`endif

endmodule

>>> src/lr_fifo.sv
module lr_fifo import lr_pkg::*; #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_BITS = $clog2(DEPTH + 1);
	localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(DEPTH - 1);
	localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(DEPTH);

	logic [WIDTH-1:0]    mem_q [DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q;
	logic [PTR_BITS-1:0] rd_ptr_q;
	logic [CNT_BITS-1:0] count_q;
	logic                do_wr;
	logic                do_rd;

	assign full    = (count_q == CNT_FULL);
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	// Advance pointers and word count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Store the incoming word
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

>>> src/lr_front.sv
module lr_front import lr_pkg::*; (
	input  item_t      item,
	output cmd_entry_t entry
);

	logic [DELTA_BITS-1:0] dx;
	logic [DELTA_BITS-1:0] dy;
	logic [DELTA_BITS-1:0] adx;
	logic [DELTA_BITS-1:0] ady;
	logic                  dx_zero;
	logic                  dy_zero;
	logic                  x_major;
	line_setup_t           setup;

	// Signed deltas and their magnitudes
	assign dx      = {1'b0, item.x_end} - {1'b0, item.x_start};
	assign dy      = {1'b0, item.y_end} - {1'b0, item.y_start};
	assign adx     = dx[DELTA_BITS-1] ? (~dx + 1'b1) : dx;
	assign ady     = dy[DELTA_BITS-1] ? (~dy + 1'b1) : dy;
	assign dx_zero = (dx == '0);
	assign dy_zero = (dy == '0);
	assign x_major = (adx >= ady);

	// Classify the line and pick the starting point of the walk
	always_comb begin
		setup             = '0;
		setup.x_start     = item.x_start;
		setup.y_start     = item.y_start;
		setup.x_end       = item.x_end;
		setup.y_end       = item.y_end;
		if (dx_zero || dy_zero) begin
			setup.mode.straight = 1'b1;
			if (dx_zero) begin
				setup.mode.major_y = 1'b1;
				setup.minor_pos    = item.x_start;
				if (item.y_start < item.y_end) begin
					setup.major_pos   = item.y_start;
					setup.major_limit = item.y_end;
				end else begin
					setup.major_pos   = item.y_end;
					setup.major_limit = item.y_start;
				end
			end else begin
				setup.minor_pos = item.y_start;
				if (item.x_start < item.x_end) begin
					setup.major_pos   = item.x_start;
					setup.major_limit = item.x_end;
				end else begin
					setup.major_pos   = item.x_end;
					setup.major_limit = item.x_start;
				end
			end
		end else begin
			setup.mode.minor_down = (dx[DELTA_BITS-1] != dy[DELTA_BITS-1]);
			if (x_major) begin
				setup.delta_major = adx;
				setup.delta_minor = ady;
				if (item.x_start <= item.x_end) begin
					setup.major_pos   = item.x_start;
					setup.major_limit = item.x_end;
					setup.minor_pos   = item.y_start;
				end else begin
					setup.major_pos   = item.x_end;
					setup.major_limit = item.x_start;
					setup.minor_pos   = item.y_end;
				end
			end else begin
				setup.mode.major_y = 1'b1;
				setup.delta_major  = ady;
				setup.delta_minor  = adx;
				if (item.y_start <= item.y_end) begin
					setup.major_pos   = item.y_start;
					setup.major_limit = item.y_end;
					setup.minor_pos   = item.x_start;
				end else begin
					setup.major_pos   = item.y_end;
					setup.major_limit = item.y_start;
					setup.minor_pos   = item.x_end;
				end
			end
			setup.error_term = {1'b0, setup.delta_minor} - {1'b0, setup.delta_major};
		end
	end

	assign entry.command = item.command;
	assign entry.setup   = setup;

endmodule

>>> src/lr_back.sv
module lr_back import lr_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [COORD_BITS-1:0] grid_size,
	input  logic                  cmd_valid,
	input  cmd_entry_t            cmd_word,
	output logic                  cmd_pop,
	input  logic                  res_room,
	output logic                  res_push,
	output result_t               res_word,
	output back_status_t          status
);

	logic        active_q;
	logic        active_d;
	phase_t      phase_q;
	phase_t      phase_d;
	line_setup_t line_q;
	line_setup_t line_d;

	logic                       go;
	logic                       err_ge;
	logic                       fin;
	logic [COORD_BITS-1:0]      walk_x;
	logic [COORD_BITS-1:0]      walk_y;
	logic [COORD_BITS-1:0]      major_inc;
	logic [COORD_BITS-1:0]      pix_x;
	logic [COORD_BITS-1:0]      pix_y;
	logic                       pix_last;
	logic signed [ERR_BITS-1:0] err_sub;

	assign go        = cmd_valid && res_room;
	assign cmd_pop   = go;
	assign walk_x    = line_q.mode.major_y ? line_q.minor_pos : line_q.major_pos;
	assign walk_y    = line_q.mode.major_y ? line_q.major_pos : line_q.minor_pos;
	assign major_inc = line_q.major_pos + 1'b1;
	assign fin       = (line_q.major_pos == line_q.major_limit);
	assign err_ge    = !line_q.error_term[ERR_BITS-1];
	assign err_sub   = err_ge ? line_q.error_term - {1'b0, line_q.delta_major}
	                          : line_q.error_term;

	// Execute one command word and choose the pixel to emit
	always_comb begin
		active_d = active_q;
		phase_d  = phase_q;
		line_d   = line_q;
		res_push = 1'b0;
		pix_x    = walk_x;
		pix_y    = walk_y;
		pix_last = 1'b0;
		if (go) begin
			if (cmd_word.command == CMD_START) begin
				line_d   = cmd_word.setup;
				active_d = 1'b1;
				phase_d  = PH_WALK;
			end else if (active_q) begin
				res_push = 1'b1;
				case (phase_q)
					PH_WALK: begin
						if (line_q.mode.straight) begin
							pix_last = fin;
							if (fin) begin
								active_d = 1'b0;
							end else begin
								line_d.major_pos = major_inc;
							end
						end else begin
							if (err_ge) begin
								line_d.minor_pos = line_q.mode.minor_down
									? line_q.minor_pos - 1'b1
									: line_q.minor_pos + 1'b1;
							end
							line_d.error_term = err_sub + {1'b0, line_q.delta_minor};
							line_d.major_pos  = major_inc;
							if (major_inc == line_q.major_limit) begin
								phase_d = PH_FIRST;
							end
						end
					end
					PH_FIRST: begin
						pix_x   = line_q.x_start;
						pix_y   = line_q.y_start;
						phase_d = PH_SECOND;
					end
					default: begin
						pix_x    = line_q.x_end;
						pix_y    = line_q.y_end;
						pix_last = 1'b1;
						active_d = 1'b0;
						phase_d  = PH_WALK;
					end
				endcase
			end
		end
	end

	// Tag the pixel against the grid
	always_comb begin
		res_word.pixel_x = pix_x;
		res_word.pixel_y = pix_y;
		res_word.visible = (pix_x != '0) && (pix_y != '0) &&
		                   (pix_x < grid_size) && (pix_y < grid_size);
		res_word.last    = pix_last;
	end

	// Hold line control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			phase_q  <= PH_WALK;
		end else begin
			active_q <= active_d;
			phase_q  <= phase_d;
		end
	end

	// Hold walk position, error term and endpoints
	always_ff @(posedge clk) begin
		line_q <= line_d;
	end

	assign status.active = active_q;
	assign status.phase  = phase_q;

endmodule

>>> bench/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import lr_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int MAX_COORD   = (1 << COORD_BITS) - 1;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  push      = 1'b0;
	item_t                 item      = '0;
	logic                  full;
	logic                  empty;
	logic                  pop       = 1'b0;
	result_t               result;
	logic                  grid_we   = 1'b0;
	logic [COORD_BITS-1:0] grid_data = '0;

	line_rasterizer DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.item      (item),
		.full      (full),
		.empty     (empty),
		.pop       (pop),
		.result    (result),
		.grid_we   (grid_we),
		.grid_data (grid_data)
	);

	// Words waiting to be pushed, pixels waiting to come out
	item_t   word_q[$];
	result_t pixel_q[$];

	// Predicted line state
	logic [COORD_BITS-1:0] grid_cur = GRID_RESET;
	logic                  line_on  = 1'b0;
	line_mode_t            lmode    = '0;
	phase_t                lphase   = PH_WALK;
	logic [COORD_BITS-1:0] maj_pos  = '0;
	logic [COORD_BITS-1:0] min_pos  = '0;
	logic [COORD_BITS-1:0] maj_lim  = '0;
	int                    err_acc  = 0;
	int                    d_maj    = 0;
	int                    d_min    = 0;
	logic [COORD_BITS-1:0] end_x0, end_y0, end_x1, end_y1;

	// Run bookkeeping
	logic    took_item   = 1'b0;
	int      n_words     = 0;
	int      n_pixels    = 0;
	int      n_starts    = 0;
	int      n_err       = 0;
	int      cycles      = 0;
	int      hold_left   = 0;
	int      next_hold   = 120;
	int      n_holds     = 0;
	int      burst_left  = 0;
	int      gap_left    = 0;
	int      pop_mode    = 0;
	int      mode_left   = 0;
	logic [15:0] pop_pattern = 16'hffff;
	int      grid_gen    = GRID_RESET;
	int      grid_rand   = 0;
	result_t want;
	logic    hold_on;

	assign hold_on = (hold_left > 0);

	// Clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Append an expected pixel
	task automatic expect_pixel(result_t p);
		pixel_q = {pixel_q, p};
	endtask

	// Append a word to send
	task automatic add_word(item_t w);
		word_q = {word_q, w};
	endtask

	function automatic result_t make_pixel(logic [COORD_BITS-1:0] x, logic [COORD_BITS-1:0] y,
			logic fin);
		result_t r;
		r.pixel_x = x;
		r.pixel_y = y;
		r.visible = (x > 0) && (y > 0) && (x < grid_cur) && (y < grid_cur);
		r.last    = fin;
		return r;
	endfunction

	// Set up the stepper for a new line from two endpoints
	task automatic load_line(item_t w);
		int dx, dy, adx, ady;
		dx  = int'(w.x_end) - int'(w.x_start);
		dy  = int'(w.y_end) - int'(w.y_start);
		adx = (dx < 0) ? -dx : dx;
		ady = (dy < 0) ? -dy : dy;
		end_x0  = w.x_start;
		end_y0  = w.y_start;
		end_x1  = w.x_end;
		end_y1  = w.y_end;
		line_on = 1'b1;
		lphase  = PH_WALK;
		err_acc = 0;
		if (dx == 0 || dy == 0) begin
			lmode.straight   = 1'b1;
			lmode.minor_down = 1'b0;
			lmode.major_y    = (dx == 0);
			d_maj = 0;
			d_min = 0;
			if (dx == 0) begin
				min_pos = w.x_start;
				maj_pos = (w.y_start < w.y_end) ? w.y_start : w.y_end;
				maj_lim = (w.y_start < w.y_end) ? w.y_end : w.y_start;
			end else begin
				min_pos = w.y_start;
				maj_pos = (w.x_start < w.x_end) ? w.x_start : w.x_end;
				maj_lim = (w.x_start < w.x_end) ? w.x_end : w.x_start;
			end
		end else begin
			lmode.straight   = 1'b0;
			lmode.minor_down = ((dx > 0) != (dy > 0));
			if (adx >= ady) begin
				lmode.major_y = 1'b0;
				d_maj = adx;
				d_min = ady;
				if (w.x_start <= w.x_end) begin
					maj_pos = w.x_start; maj_lim = w.x_end; min_pos = w.y_start;
				end else begin
					maj_pos = w.x_end; maj_lim = w.x_start; min_pos = w.y_end;
				end
			end else begin
				lmode.major_y = 1'b1;
				d_maj = ady;
				d_min = adx;
				if (w.y_start <= w.y_end) begin
					maj_pos = w.y_start; maj_lim = w.y_end; min_pos = w.x_start;
				end else begin
					maj_pos = w.y_end; maj_lim = w.y_start; min_pos = w.x_end;
				end
			end
			err_acc = d_min - d_maj;
		end
	endtask

	// Advance the predicted rasterizer by one accepted word
	task automatic rasterize_word(item_t w);
		logic [COORD_BITS-1:0] px, py;
		logic fin;
		if (w.command == CMD_START) begin
			load_line(w);
			n_starts++;
			return;
		end
		if (!line_on)
			return;
		if (lphase == PH_FIRST) begin
			expect_pixel(make_pixel(end_x0, end_y0, 1'b0));
			lphase = PH_SECOND;
			return;
		end
		if (lphase == PH_SECOND) begin
			expect_pixel(make_pixel(end_x1, end_y1, 1'b1));
			line_on = 1'b0;
			lphase  = PH_WALK;
			return;
		end
		px = lmode.major_y ? min_pos : maj_pos;
		py = lmode.major_y ? maj_pos : min_pos;
		if (lmode.straight) begin
			fin = (maj_pos == maj_lim);
			expect_pixel(make_pixel(px, py, fin));
			if (fin)
				line_on = 1'b0;
			else
				maj_pos = maj_pos + 1'b1;
			return;
		end
		expect_pixel(make_pixel(px, py, 1'b0));
		if (err_acc >= 0) begin
			min_pos = lmode.minor_down ? min_pos - 1'b1 : min_pos + 1'b1;
			err_acc -= d_maj;
		end
		err_acc += d_min;
		maj_pos = maj_pos + 1'b1;
		if (maj_pos == maj_lim)
			lphase = PH_FIRST;
	endtask

	task automatic note_error(string what, result_t exp_px, result_t got_px);
		n_err++;
		if (n_err <= 10)
			$display("[%0t] %s: expected x=%0d y=%0d vis=%0b last=%0b,%s%0d y=%0d vis=%0b last=%0b",
				$realtime, what, exp_px.pixel_x, exp_px.pixel_y, exp_px.visible,
				exp_px.last, " got x=", got_px.pixel_x, got_px.pixel_y, got_px.visible,
				got_px.last);
	endtask

	// Monitor: sample handshakes, predict on pushed words, check popped pixels
	always @(posedge clk) begin
		if (arst_n) begin
			took_item <= push && !full;
			if (grid_we)
				grid_cur = grid_data;
			if (pop && !empty) begin
				if (pixel_q.size() == 0) begin
					note_error("unexpected pixel", '0, result);
				end else begin
					want = pixel_q.pop_front();
					if (result.pixel_x !== want.pixel_x || result.pixel_y !== want.pixel_y ||
							result.visible !== want.visible || result.last !== want.last)
						note_error("pixel mismatch", want, result);
					n_pixels <= n_pixels + 1;
				end
			end
			if (push && !full) begin
				rasterize_word(item);
				n_words <= n_words + 1;
			end
		end
	end

	// Driver: offer words in bursts with random gaps; no gaps while the output is held off
	always @(negedge clk) begin
		if (!arst_n) begin
			push <= 1'b0;
		end else if (!push || took_item) begin
			if (gap_left > 0 && !hold_on) begin
				gap_left--;
				push <= 1'b0;
			end else if (word_q.size() > 0) begin
				item <= word_q.pop_front();
				push <= 1'b1;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(0, 20);
					gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end
			end else begin
				push <= 1'b0;
			end
		end
	end

	// Receiver: pop always, on a shifting pattern or at random, in a mode that changes every so often
	always @(negedge clk) begin
		if (mode_left == 0) begin
			pop_mode    = $urandom_range(0, 2);
			pop_pattern = 16'($urandom);
			mode_left   = $urandom_range(16, 96);
		end else begin
			mode_left--;
		end
		pop_pattern = {pop_pattern[14:0], pop_pattern[15]};
		case (pop_mode)
			0: pop <= !hold_on;
			1: pop <= pop_pattern[0] && !hold_on;
			default: pop <= ($urandom_range(0, 3) != 0) && !hold_on;
		endcase
	end

	// Long output hold-off, started at fixed word counts so the input backs up
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end else if (n_words >= next_hold) begin
			hold_left <= 150;
			next_hold <= next_hold + 400;
			n_holds   <= n_holds + 1;
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d pixels still expected", cycles, pixel_q.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	function automatic item_t make_word(cmd_t cmd, int xs, int ys, int xe, int ye);
		item_t w;
		w.command = cmd;
		w.x_start = COORD_BITS'(xs);
		w.y_start = COORD_BITS'(ys);
		w.x_end   = COORD_BITS'(xe);
		w.y_end   = COORD_BITS'(ye);
		return w;
	endfunction

	function automatic int pixel_count(int xs, int ys, int xe, int ye);
		int adx, ady, span;
		adx  = (xe > xs) ? xe - xs : xs - xe;
		ady  = (ye > ys) ? ye - ys : ys - ye;
		span = (adx > ady) ? adx : ady;
		return (adx == 0 || ady == 0) ? span + 1 : span + 2;
	endfunction

	// Move a coordinate by an offset, reflecting back if it leaves the grid
	function automatic int bounce(int base, int off);
		return (base + off < 0 || base + off > MAX_COORD) ? base - off : base + off;
	endfunction

	function automatic int near_value(int v);
		int r;
		r = v - 2 + $urandom_range(0, 3);
		return (r < 0) ? 0 : (r > MAX_COORD) ? MAX_COORD : r;
	endfunction

	// Queue a start word and a number of step words with random leftover fields
	task automatic queue_line(int xs, int ys, int xe, int ye, int steps);
		add_word(make_word(CMD_START, xs, ys, xe, ye));
		repeat (steps)
			add_word(make_word(CMD_STEP, $urandom, $urandom, $urandom, $urandom));
	endtask

	task automatic queue_directed();
		// step with no line in progress
		add_word(make_word(CMD_STEP, 0, MAX_COORD, 0, MAX_COORD));
		// single point
		queue_line(5, 5, 5, 5, 1);
		// horizontal right to left at the far corner, vertical at the edge
		queue_line(MAX_COORD, 0, MAX_COORD - 2, 0, 3);
		queue_line(0, MAX_COORD, 0, MAX_COORD - 1, 2);
		// one line per sloped stepper mode: x or y major, minor up or down
		queue_line(0, 0, 2, 1, 4);
		queue_line(MAX_COORD, MAX_COORD, MAX_COORD - 1, MAX_COORD - 2, 4);
		queue_line(10, 3, 8, 4, 4);
		queue_line(3, 10, 4, 8, 4);
		// start during a line, then an extra step past the end
		queue_line(0, 0, 6, 6, 1);
		queue_line(7, 7, 7, 7, 2);
	endtask

	// Mostly complete lines with random content; some cut short, some overrun
	task automatic queue_random(int budget, bit with_long);
		int added, sel, span, xs, ys, xe, ye, n, steps, r;
		added = 0;
		if (with_long) begin
			xs = $urandom_range(0, MAX_COORD);
			ys = $urandom_range(0, MAX_COORD);
			xe = bounce(xs, $urandom_range(0, 240) - 120);
			ye = bounce(ys, $urandom_range(0, 240) - 120);
			queue_line(xs, ys, xe, ye, pixel_count(xs, ys, xe, ye));
		end
		while (added < budget) begin
			sel = $urandom_range(0, 9);
			if (sel < 2) begin
				xs = $urandom_range(0, 3);
				ys = $urandom_range(0, 3);
			end else if (sel < 4) begin
				xs = near_value(grid_gen);
				ys = near_value(grid_gen);
			end else if (sel == 4) begin
				xs = $urandom_range(MAX_COORD - 7, MAX_COORD);
				ys = $urandom_range(MAX_COORD - 7, MAX_COORD);
			end else begin
				xs = $urandom_range(0, MAX_COORD);
				ys = $urandom_range(0, MAX_COORD);
			end
			span = ($urandom_range(0, 3) == 0) ? 40 : 8;
			xe = bounce(xs, $urandom_range(0, 2 * span) - span);
			ye = bounce(ys, $urandom_range(0, 2 * span) - span);
			case ($urandom_range(0, 7))
				0: xe = xs;
				1: ye = ys;
				2: ye = bounce(ys, $urandom_range(0, 1) ? xe - xs : xs - xe);
				default: ;
			endcase
			n = pixel_count(xs, ys, xe, ye);
			r = $urandom_range(0, 99);
			if (r < 80)
				steps = n;
			else if (r < 90)
				steps = $urandom_range(0, n - 1);
			else
				steps = n + $urandom_range(1, 3);
			queue_line(xs, ys, xe, ye, steps);
			added += 1 + steps;
		end
	endtask

	// Wait until every word is in and every pixel is out, then let the pipeline drain
	task automatic wait_idle();
		while (word_q.size() > 0 || push || pixel_q.size() > 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_grid(int value);
		@(negedge clk);
		grid_we   <= 1'b1;
		grid_data <= COORD_BITS'(value);
		grid_gen  = value;
		@(negedge clk);
		grid_we   <= 1'b0;
		@(negedge clk);
	endtask

	// Stimulus: directed lines, then random phases across several grid sizes
	initial begin
		int grid_seq[4];
		grid_rand   = $urandom_range(3, MAX_COORD - 1);
		grid_seq[0] = MAX_COORD;
		grid_seq[1] = 2;
		grid_seq[2] = grid_rand;
		grid_seq[3] = GRID_RESET;
		queue_directed();
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		queue_random(150, 1'b0);
		for (int p = 0; p < 4; p++) begin
			wait_idle();
			write_grid(grid_seq[p]);
			queue_random(150, (p == 0) || (p == 2));
		end
		wait_idle();
		repeat (8) @(negedge clk);
		n_err += pixel_q.size();
		$display("Pushed %0d words (%0d line starts), checked %0d pixels, %0d output hold-offs",
			n_words, n_starts, n_pixels, n_holds);
		$display("Grid sizes: %0d, %0d, 2, %0d, %0d; mismatches: %0d",
			GRID_RESET, MAX_COORD, grid_rand, GRID_RESET, n_err);
		if (n_err == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
